/* rtl/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 decoder: the request and
// response payloads, the queue entry between front and back, and the lead
// byte codes.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	// One request transaction: a string byte and/or an end-of-string mark.
	typedef struct packed {
		logic       has_byte;
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_item_t;

	// One response transaction: a code unit or an end-of-string status.
	typedef struct packed {
		logic        is_status;
		logic [15:0] code_unit;
		logic        ok;
		logic [23:0] chars_consumed;
		logic        last_of_run;
	} out_item_t;

	// Everything one request produces, handed from the front to the back.
	typedef struct packed {
		logic [1:0]  n_units;
		logic [15:0] unit0;
		logic [15:0] unit1;
		logic        has_status;
		logic        ok;
		logic [23:0] count;
	} q_entry_t;

	// Queue depth between the front and the back.
	localparam int unsigned Q_DEPTH = 4;

	// Lead byte classes, by high nibble.
	localparam logic [3:0] LEAD_FOUR  = 4'hF;
	localparam logic [3:0] LEAD_THREE = 4'hE;
	localparam logic [3:0] LEAD_TWO_D = 4'hD;
	localparam logic [3:0] LEAD_TWO_C = 4'hC;

	// Continuation counts of the sequence lengths.
	localparam logic [1:0] SEQ_TWO   = 2'd1;
	localparam logic [1:0] SEQ_THREE = 2'd2;
	localparam logic [1:0] SEQ_FOUR  = 2'd3;

	// Surrogate construction.
	localparam logic [20:0] SUPP_BASE  = 21'h10000;
	localparam logic [15:0] HIGH_SURR  = 16'hD800;
	localparam logic [15:0] LOW_SURR   = 16'hDC00;

endpackage

/* rtl/u8u16_front.sv */
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts one request per cycle when accept is high; decodes the UTF-8 byte
// against the running sequence state, building an entry of all its results.
// ----------------------------------------------------------------------------
module u8u16_front #(
	parameter int unsigned COUNT_WIDTH = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [23:0]         unit_limit,
	input  u8u16_pkg::in_item_t req,
	input  logic                accept,
	output logic                push,
	output u8u16_pkg::q_entry_t entry
);
	import u8u16_pkg::*;

	localparam int unsigned CMP_W = ((COUNT_WIDTH > 24) ? COUNT_WIDTH : 24) + 1;

	// Saturating counter add.
	function automatic logic [COUNT_WIDTH-1:0] sat_add(
		input logic [COUNT_WIDTH-1:0] a,
		input logic [1:0]             k
	);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, a} + (COUNT_WIDTH+1)'(k);
		return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
	endfunction

	logic [1:0]             pend_q, pend_n;
	logic [1:0]             seq_q, seq_n;
	logic [20:0]            acc_q, acc_n;
	logic                   failed_q, failed_n;
	logic [COUNT_WIDTH-1:0] units_q, units_n;
	logic [COUNT_WIDTH-1:0] chars_q, chars_n;
	logic [20:0]            offset;
	logic                   limit_hit;
	logic [CMP_W-1:0]       chars_ext;

	// Surrogate limit check: the unit count plus one meets a nonzero limit.
	assign limit_hit = (unit_limit != 24'd0) &&
		((CMP_W'(units_q) + CMP_W'(1)) == CMP_W'(unit_limit));

	// Decode of the current byte and the next sequence state.
	always_comb begin
		pend_n   = pend_q;
		seq_n    = seq_q;
		acc_n    = acc_q;
		failed_n = failed_q;
		units_n  = units_q;
		chars_n  = chars_q;
		offset   = '0;
		entry    = '0;
		if (req.has_byte && !failed_q) begin
			if (pend_q != 2'd0) begin
				acc_n  = {acc_q[14:0], req.in_byte[5:0]};
				pend_n = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					offset = acc_n - SUPP_BASE;
					if (acc_n[20:16] != 5'd0) begin
						if (limit_hit) begin
							failed_n = 1'b1;
						end else begin
							entry.n_units = 2'd2;
							entry.unit0   = {5'd0, offset[20:10]} | HIGH_SURR;
							entry.unit1   = {6'd0, offset[9:0]} | LOW_SURR;
							units_n       = sat_add(units_q, 2'd2);
							chars_n       = sat_add(chars_q, (seq_q == SEQ_FOUR) ? 2'd2 : 2'd1);
						end
					end else begin
						entry.n_units = 2'd1;
						entry.unit0   = acc_n[15:0];
						units_n       = sat_add(units_q, 2'd1);
						chars_n       = sat_add(chars_q, (seq_q == SEQ_FOUR) ? 2'd2 : 2'd1);
					end
				end
			end else if (!req.in_byte[7]) begin
				entry.n_units = 2'd1;
				entry.unit0   = {8'd0, req.in_byte};
				units_n       = sat_add(units_q, 2'd1);
				chars_n       = sat_add(chars_q, 2'd1);
			end else begin
				unique case (req.in_byte[7:4])
					LEAD_FOUR: begin
						seq_n  = SEQ_FOUR;
						acc_n  = {18'd0, req.in_byte[2:0]};
						pend_n = SEQ_FOUR;
					end
					LEAD_THREE: begin
						seq_n  = SEQ_THREE;
						acc_n  = {17'd0, req.in_byte[3:0]};
						pend_n = SEQ_THREE;
					end
					LEAD_TWO_D, LEAD_TWO_C: begin
						seq_n  = SEQ_TWO;
						acc_n  = {16'd0, req.in_byte[4:0]};
						pend_n = SEQ_TWO;
					end
					default: begin
						failed_n = 1'b1;
					end
				endcase
			end
		end
		chars_ext = CMP_W'(chars_n);
		// End of string: report status and start the next string clean.
		if (req.end_of_string) begin
			entry.has_status = 1'b1;
			entry.ok         = !failed_n && (pend_n == 2'd0);
			entry.count      = chars_ext[23:0];
			pend_n   = '0;
			seq_n    = '0;
			acc_n    = '0;
			failed_n = 1'b0;
			units_n  = '0;
			chars_n  = '0;
		end
		push = accept && ((entry.n_units != 2'd0) || entry.has_status);
	end

	// Sequence state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			seq_q    <= '0;
			acc_q    <= '0;
			failed_q <= 1'b0;
			units_q  <= '0;
			chars_q  <= '0;
		end else if (accept) begin
			pend_q   <= pend_n;
			seq_q    <= seq_n;
			acc_q    <= acc_n;
			failed_q <= failed_n;
			units_q  <= units_n;
			chars_q  <= chars_n;
		end
	end

`ifndef SYNTH
	// A status entry always leaves the sequence state cleared.
	a_status_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(push && entry.has_status) |=> (pend_q == 2'd0 && units_q == '0 && !failed_q))
		else $error("state not cleared after status");
	// A surrogate pair is never queued when the limit is hit.
	a_limit_blocks_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(push && entry.n_units == 2'd2) |-> !limit_hit)
		else $error("surrogate pair emitted at unit limit");
`endif

endmodule

/* rtl/u8u16_fifo.sv */
// ----------------------------------------------------------------------------
// u8u16_fifo
// Short register queue that decouples the decoding front from the result
// sequencing back.
// ----------------------------------------------------------------------------
module u8u16_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  u8u16_pkg::q_entry_t push_data,
	input  logic                pop,
	output logic                full,
	output logic                head_valid,
	output u8u16_pkg::q_entry_t head
);
	import u8u16_pkg::*;

	localparam int unsigned PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

	q_entry_t         data_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = data_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue underflow");
`endif

endmodule

/* rtl/u8u16_back.sv */
// ----------------------------------------------------------------------------
// u8u16_back
// Walks the results of the queue head one response transaction per cycle while
// rsp_ready is high and marks the last result caused by each request.
// ----------------------------------------------------------------------------
module u8u16_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  u8u16_pkg::q_entry_t  head,
	output logic                 pop,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output u8u16_pkg::out_item_t rsp
);
	import u8u16_pkg::*;

	logic [1:0] idx_q;
	logic [1:0] total;
	logic       is_last;

	assign total     = head.n_units + {1'b0, head.has_status};
	assign is_last   = (idx_q == total - 2'd1);
	assign rsp_valid = head_valid;
	assign pop       = rsp_valid && rsp_ready && is_last;

	// Select the current result of the head entry.
	always_comb begin
		rsp             = '0;
		rsp.last_of_run = is_last;
		if (idx_q < head.n_units) begin
			rsp.code_unit = (idx_q == 2'd0) ? head.unit0 : head.unit1;
		end else begin
			rsp.is_status      = 1'b1;
			rsp.ok             = head.ok;
			rsp.chars_consumed = head.count;
		end
	end

	// Result index within the head entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (rsp_valid && rsp_ready) begin
			idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

`ifndef SYNTH
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (idx_q < total))
		else $error("result index beyond entry");
`endif

endmodule

/* rtl/utf8_to_utf16_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// The first result of a request is offered from the registered queue entry.
// Accepts one byte per cycle while the queue is not full; results drain one per
// cycle while rsp_ready is high, a surrogate pair as two results, a status as one.
// A four-entry queue between decoder and result sequencer absorbs the bursts.
// Reset clears the sequence state, the queue and unit_limit at once.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder #(
	parameter int unsigned COUNT_WIDTH = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  u8u16_pkg::in_item_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output u8u16_pkg::out_item_t rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [23:0]          cfg_data
);
	import u8u16_pkg::*;

	logic [23:0] unit_limit_q;
	logic        accept;
	logic        push;
	logic        full;
	logic        pop;
	logic        head_valid;
	q_entry_t    push_data;
	q_entry_t    head;

	assign cfg_ready = 1'b1;
	assign req_ready = !full;
	assign accept    = req_valid && req_ready;

	// Unit limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unit_limit_q <= cfg_data;
		end
	end

	u8u16_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.unit_limit(unit_limit_q),
		.req       (req),
		.accept    (accept),
		.push      (push),
		.entry     (push_data)
	);

	u8u16_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (full),
		.head_valid(head_valid),
		.head      (head)
	);

	u8u16_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

/* tb/utf16_stream_checker.sv */
// ----------------------------------------------------------------------------
// utf16_stream_checker
// Watches the request, response and configuration channels of the UTF-8 to
// UTF-16 decoder. Every accepted request is run through a local transcoder
// that predicts the code units and status it must cause, and every accepted
// response is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module utf16_stream_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_ready,
	input  u8u16_pkg::in_item_t  req,
	input  logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  u8u16_pkg::out_item_t rsp,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [23:0]          cfg_data,
	output int unsigned          fail_count,
	output int unsigned          backlog
);
	import u8u16_pkg::*;

	localparam logic [23:0] COUNT_MAX = '1;

	// Local copy of the limit register and of the per-string decode state.
	logic [23:0] unit_limit;
	logic [1:0]  cont_left;
	logic [1:0]  seq_cont;
	logic [20:0] cp_acc;
	logic        str_failed;
	logic [23:0] units_out;
	logic [23:0] chars_done;

	// Predicted responses still to arrive, and those of the current request.
	out_item_t   awaited_rsp[$];
	out_item_t   run_rsp[$];
	int unsigned n_fail = 0;
	int unsigned n_awaited = 0;

	assign fail_count = n_fail;
	assign backlog    = n_awaited;

	// Saturating counter step.
	function automatic logic [23:0] count_up(input logic [23:0] a, input logic [1:0] inc);
		logic [24:0] sum;
		sum = {1'b0, a} + inc;
		return (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[23:0];
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] want,
		input logic [63:0] got);
		$display("%0t mismatch in %s: expected 0x%0h, got 0x%0h", $time, field, want, got);
		n_fail++;
	endtask

	task automatic restart_string();
		cont_left  = '0;
		seq_cont   = '0;
		cp_acc     = '0;
		str_failed = 1'b0;
		units_out  = '0;
		chars_done = '0;
	endtask

	task automatic emit_unit(input logic [15:0] unit);
		out_item_t r;
		r = '0;
		r.code_unit = unit;
		run_rsp = {run_rsp, r};
		units_out = count_up(units_out, 2'd1);
	endtask

	// A sequence is complete: one unit, a surrogate pair, or a limit failure.
	task automatic complete_char();
		logic [20:0] off;
		if (cp_acc >= SUPP_BASE) begin
			if (unit_limit != '0 && {1'b0, units_out} + 25'd1 == {1'b0, unit_limit}) begin
				str_failed = 1'b1;
				return;
			end
			off = cp_acc - SUPP_BASE;
			emit_unit(16'(off >> 10) | HIGH_SURR);
			emit_unit({6'd0, off[9:0]} | LOW_SURR);
		end else begin
			emit_unit(cp_acc[15:0]);
		end
		chars_done = count_up(chars_done, (seq_cont == SEQ_FOUR) ? 2'd2 : 2'd1);
	endtask

	// One string byte: continuation, plain ASCII, or a lead byte.
	task automatic take_byte(input logic [7:0] b);
		if (str_failed)
			return;
		if (cont_left != '0) begin
			cp_acc    = {cp_acc[14:0], b[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left == '0)
				complete_char();
			return;
		end
		if (!b[7]) begin
			emit_unit({8'd0, b});
			chars_done = count_up(chars_done, 2'd1);
			return;
		end
		case (b[7:4])
			LEAD_FOUR: begin
				seq_cont = SEQ_FOUR;
				cp_acc   = {18'd0, b[2:0]};
			end
			LEAD_THREE: begin
				seq_cont = SEQ_THREE;
				cp_acc   = {17'd0, b[3:0]};
			end
			LEAD_TWO_D, LEAD_TWO_C: begin
				seq_cont = SEQ_TWO;
				cp_acc   = {16'd0, b[4:0]};
			end
			default: begin
				// A continuation byte with nothing pending fails the string.
				str_failed = 1'b1;
				return;
			end
		endcase
		cont_left = seq_cont;
	endtask

	// Predict every response of one request transaction.
	task automatic predict_request(input in_item_t item);
		out_item_t st;
		run_rsp.delete();
		if (item.has_byte)
			take_byte(item.in_byte);
		if (item.end_of_string) begin
			st = '0;
			st.is_status      = 1'b1;
			st.ok             = !str_failed && cont_left == '0;
			st.chars_consumed = chars_done;
			run_rsp = {run_rsp, st};
			restart_string();
		end
		if (run_rsp.size() != 0)
			run_rsp[run_rsp.size() - 1].last_of_run = 1'b1;
		awaited_rsp = {awaited_rsp, run_rsp};
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (awaited_rsp.size() == 0) begin
			report_mismatch("result with nothing awaited", '0, got);
			return;
		end
		want = awaited_rsp.pop_front();
		if (got.is_status !== want.is_status)
			report_mismatch("is_status", want.is_status, got.is_status);
		if (got.code_unit !== want.code_unit)
			report_mismatch("code_unit", want.code_unit, got.code_unit);
		if (got.ok !== want.ok)
			report_mismatch("ok", want.ok, got.ok);
		if (got.chars_consumed !== want.chars_consumed)
			report_mismatch("chars_consumed", want.chars_consumed, got.chars_consumed);
		if (got.last_of_run !== want.last_of_run)
			report_mismatch("last_of_run", want.last_of_run, got.last_of_run);
	endtask

	// Sample all three channels at each edge; responses are compared first.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_string();
			unit_limit = '0;
			awaited_rsp.delete();
			n_awaited <= 0;
		end else begin
			if (rsp_valid && rsp_ready)
				check_result(rsp);
			if (cfg_valid && cfg_ready)
				unit_limit = cfg_data;
			if (req_valid && req_ready)
				predict_request(req);
			n_awaited <= awaited_rsp.size();
		end
	end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives the UTF-8 to UTF-16 decoder with directed strings covering every
// sequence length, surrogate pairs, stray and truncated sequences and the
// unit limit, then with random strings over several limit settings. Both
// channels idle at random; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
	import u8u16_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 300000;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned N_PHASES      = 6;
	localparam int unsigned PHASE_ITEMS   = 24;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	in_item_t    req;
	logic        rsp_valid;
	logic        rsp_ready;
	out_item_t   rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [23:0] cfg_data;

	int unsigned fail_count;
	int unsigned backlog;
	int unsigned n_items = 0;
	int unsigned cycles = 0;
	bit          req_idle = 1'b1;
	bit          rsp_idle = 1'b1;

	utf8_to_utf16_decoder #(
		.COUNT_WIDTH(24)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	utf16_stream_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.backlog   (backlog)
	);

	// Clock and a single reset at the start.
	initial begin
		clk    = 1'b0;
		arst_n = 1'b0;
		fork
			forever #4 clk = ~clk;
			begin
				repeat (9) @(posedge clk);
				arst_n <= 1'b1;
			end
		join_none
	end

	// Watchdog on the cycle count.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[utf8_to_utf16_decoder] ERROR");
		$finish;
	end

	// Response side: a random stall before each transaction.
	initial begin
		int unsigned hold;
		rsp_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			hold = rsp_idle ? $urandom_range(0, 8) : 0;
			if (hold != 0) begin
				rsp_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// One request transaction, after a random gap.
	task automatic send_req(input in_item_t item);
		int unsigned gap;
		gap = req_idle ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		if (item.has_byte || item.end_of_string)
			n_items++;
	endtask

	// A whole string; the end mark rides on the last byte or follows alone.
	task automatic send_string(input logic [7:0] text[$], input bit eos_on_last,
		input bit noisy);
		in_item_t item;
		foreach (text[i]) begin
			if (noisy && $urandom_range(0, 19) == 0) begin
				item = {1'b0, 8'($urandom), 1'b0};
				send_req(item);
			end
			item.has_byte      = 1'b1;
			item.in_byte       = text[i];
			item.end_of_string = eos_on_last && (i == text.size() - 1);
			send_req(item);
		end
		if (!eos_on_last || text.size() == 0) begin
			item = {1'b0, 8'($urandom), 1'b1};
			send_req(item);
		end
	endtask

	function automatic logic [7:0] cont_byte();
		return ($urandom_range(0, 7) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)};
	endfunction

	// Mostly well-formed random strings, with stray bytes and cut endings.
	task automatic random_string();
		logic [7:0]  txt[$];
		int unsigned n_chars;
		int unsigned conts;
		bit          cut;
		n_chars = $urandom_range(0, 6);
		cut     = ($urandom_range(0, 9) == 0);
		for (int c = 0; c < n_chars; c++) begin
			if ($urandom_range(0, 15) == 0)
				txt = {txt, 8'($urandom_range(8'h80, 8'hBF))};
			case ($urandom_range(0, 3))
				0: begin
					txt = {txt, 8'($urandom_range(0, 127))};
					conts = 0;
				end
				1: begin
					txt = {txt, {$urandom_range(0, 1) ? LEAD_TWO_C : LEAD_TWO_D,
						4'($urandom)}};
					conts = 1;
				end
				2: begin
					txt = {txt, {LEAD_THREE, 4'($urandom)}};
					conts = 2;
				end
				default: begin
					txt = {txt, {LEAD_FOUR, 4'($urandom)}};
					conts = 3;
				end
			endcase
			if (cut && c == n_chars - 1 && conts > 0)
				conts -= $urandom_range(1, conts);
			repeat (conts) txt = {txt, cont_byte()};
		end
		send_string(txt, 1'($urandom_range(0, 1)), 1'b1);
	endtask

	task automatic write_limit(input logic [23:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every predicted response has arrived, then let the block drain.
	task automatic settle();
		req_valid <= 1'b0;
		do @(posedge clk); while (backlog != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Stimulus: one phase per limit setting.
	initial begin
		logic [7:0]  txt[$];
		logic [23:0] phase_limit[N_PHASES];
		int unsigned goal;
		in_item_t    item;
		req_valid <= 1'b0;
		req       <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		phase_limit[0] = 24'd0;
		phase_limit[1] = 24'd3;
		phase_limit[2] = 24'd1;
		phase_limit[3] = 24'hFFFFFF;
		phase_limit[4] = 24'($urandom_range(2, 8));
		phase_limit[5] = 24'd0;
		wait (arst_n);
		@(posedge clk);
		for (int p = 0; p < N_PHASES; p++) begin
			req_idle = (p != 2 && p != 5);
			rsp_idle = (p != 3 && p != 5);
			write_limit(phase_limit[p]);
			if (p == 0) begin
				// ASCII extremes, two- and three-byte forms.
				txt = '{8'h00, 8'h7F};
				send_string(txt, 1'b1, 1'b0);
				txt = '{8'hC2, 8'hA9, 8'hD0, 8'h80};
				send_string(txt, 1'b0, 1'b0);
				txt = '{8'hEF, 8'hBF, 8'hBF};
				send_string(txt, 1'b1, 1'b0);
				// Surrogate pair, then a value above the Unicode range.
				txt = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
				send_string(txt, 1'b1, 1'b0);
				// Four-byte form of a small value gives a single unit.
				txt = '{8'hF0, 8'h80, 8'h80, 8'h41};
				send_string(txt, 1'b1, 1'b0);
				// Stray continuation byte; the rest of the string is ignored.
				txt = '{8'h80, 8'h41, 8'hBF};
				send_string(txt, 1'b1, 1'b0);
				// String ending inside a sequence.
				txt = '{8'hE2, 8'h82};
				send_string(txt, 1'b1, 1'b0);
				// Idle transaction, then an unflagged byte with the end mark.
				item = {1'b0, 8'hFF, 1'b0};
				send_req(item);
				item = {1'b0, 8'hA5, 1'b1};
				send_req(item);
			end
			if (p == 1) begin
				// Two units out, so a pair would reach the limit of three.
				txt = '{8'h41, 8'h42, 8'hF0, 8'h9F, 8'h98, 8'h80};
				send_string(txt, 1'b1, 1'b0);
			end
			goal = n_items + PHASE_ITEMS;
			while (n_items < goal)
				random_string();
			settle();
		end
		if (fail_count == 0)
			$display("[utf8_to_utf16_decoder] OK");
		else
			$display("[utf8_to_utf16_decoder] ERROR");
		$finish;
	end

endmodule
